### hdl/cdq_pkg.sv
package cdq_pkg;

  typedef enum logic [2:0] {
    KIND_READ       = 3'd0,
    KIND_OVERWRITE  = 3'd1,
    KIND_PUSH_BACK  = 3'd2,
    KIND_PUSH_FRONT = 3'd3,
    KIND_POP_BACK   = 3'd4,
    KIND_POP_FRONT  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  // decision for one request, from the pointer unit to the sequencer
  typedef struct packed {
    status_e status;
    logic    wr_en;
    logic    rd_en;
  } ctl_t;

  localparam int unsigned KindBits  = 3;
  localparam int unsigned PosBits   = 8;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned OccBits   = 9;
  localparam int unsigned StatBits  = 2;

endpackage

### hdl/cdq_ram.sv
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cdq_ptr.sv
module cdq_ptr
  import cdq_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kind_e                         kind_i,
  input  logic [PosBits-1:0]            position_i,
  input  logic                          commit_i,
  output ctl_t                          ctl_o,
  output logic [$clog2(CAPACITY)-1:0]   slot_o,
  output logic [$clog2(CAPACITY+1)-1:0] count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > PosBits) ? CW : PosBits;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;

  logic          full, empty, pos_ok;
  logic [PW-1:0] pos_ext;
  logic [AW-1:0] head_dec, head_inc, logical, slot_sum;
  logic [CW-1:0] count_dec;
  logic [AW:0]   sum;
  logic          use_sum;

  assign full      = (count_q == CW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign pos_ext   = PW'(position_i);
  assign pos_ok    = (pos_ext < PW'(count_q));
  assign count_dec = count_q - CW'(1);
  assign head_dec  = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
  assign head_inc  = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);

  // head plus logical index, wrapped with one compare and subtract
  always_comb begin
    logical = pos_ext[AW-1:0];
    use_sum = 1'b1;
    unique case (kind_i)
      KIND_PUSH_BACK:  logical = count_q[AW-1:0];
      KIND_POP_BACK:   logical = count_dec[AW-1:0];
      default:         logical = pos_ext[AW-1:0];
    endcase
    sum = {1'b0, head_q} + {1'b0, logical};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    slot_sum = sum[AW-1:0];
    if (kind_i == KIND_PUSH_FRONT || kind_i == KIND_POP_FRONT) begin
      use_sum = 1'b0;
    end
  end

  always_comb begin
    ctl_o.status = STATUS_OK;
    ctl_o.wr_en  = 1'b0;
    ctl_o.rd_en  = 1'b0;
    head_d       = head_q;
    count_d      = count_q;
    slot_o       = use_sum ? slot_sum : head_q;
    unique case (kind_i)
      KIND_READ, KIND_OVERWRITE: begin
        if (!pos_ok) begin
          ctl_o.status = STATUS_RANGE;
        end else if (kind_i == KIND_OVERWRITE) begin
          ctl_o.wr_en = 1'b1;
        end else begin
          ctl_o.rd_en = 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          ctl_o.status = STATUS_FULL;
        end else begin
          ctl_o.wr_en = 1'b1;
          count_d     = count_q + CW'(1);
        end
      end
      KIND_PUSH_FRONT: begin
        slot_o = head_dec;
        if (full) begin
          ctl_o.status = STATUS_FULL;
        end else begin
          ctl_o.wr_en = 1'b1;
          head_d      = head_dec;
          count_d     = count_q + CW'(1);
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          ctl_o.status = STATUS_EMPTY;
        end else begin
          ctl_o.rd_en = 1'b1;
          count_d     = count_dec;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          ctl_o.status = STATUS_EMPTY;
        end else begin
          ctl_o.rd_en = 1'b1;
          head_d      = head_inc;
          count_d     = count_dec;
        end
      end
      default: begin
        ctl_o.status = STATUS_OK;
      end
    endcase
  end

  assign count_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (commit_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

endmodule

### hdl/circular_deque_with_index.sv
// result path: writes, pushes and rejected requests register their word straight into the result word;
// reads and pops pass through the ring memory read register first, then into the result word.
// throughput: one request per cycle for writes, pushes, unused kinds and errors while the result
// word is taken; reads and pops hold input off while the result word waits on the read.
// reset: head and count clear to zero, the deque is empty; memory contents are not cleared.
module circular_deque_with_index
  import cdq_pkg::*;
#(
  parameter int unsigned CAPACITY     = 256,
  parameter int unsigned ELEMENT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[7:0], item_value[39:8]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // element_out[31:0], status[33:32], occupancy[42:34]
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = (ELEMENT_BITS < ValueBits) ? ELEMENT_BITS : ValueBits;

  state_e state_q, state_d;

  logic                 in_fire, out_fire;
  kind_e                kind;
  logic [PosBits-1:0]   position;
  logic [ValueBits-1:0] item_value;
  ctl_t                 ctl;
  logic [AW-1:0]        slot;
  logic [CW-1:0]        count_next;
  logic [DW-1:0]        rdata;
  logic [DW-1:0]        wdata;

  logic                 out_valid_q, out_valid_d;
  logic [ValueBits-1:0] out_elem_q, out_elem_d;
  status_e              out_status_q, out_status_d;
  logic [OccBits-1:0]   out_occ_q, out_occ_d;

  assign kind       = kind_e'(s_axis_tuser);
  assign position   = s_axis_tdata[PosBits-1:0];
  assign item_value = s_axis_tdata[PosBits+ValueBits-1:PosBits];
  assign wdata      = item_value[DW-1:0];

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  cdq_ptr #(
    .CAPACITY(CAPACITY)
  ) u_ptr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .kind_i    (kind),
    .position_i(position),
    .commit_i  (in_fire),
    .ctl_o     (ctl),
    .slot_o    (slot),
    .count_o   (count_next)
  );

  cdq_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (in_fire && ctl.wr_en),
    .waddr_i(slot),
    .wdata_i(wdata),
    .re_i   (in_fire && ctl.rd_en),
    .raddr_i(slot),
    .rdata_o(rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && ctl.rd_en) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    unique case (state_q)
      ST_IDLE: s_axis_tready = !out_valid_q || m_axis_tready;
      default: s_axis_tready = 1'b0;
    endcase
  end

  // result word register; reads fill the element in the following cycle, from the memory read
  always_comb begin
    out_valid_d  = out_valid_q;
    out_elem_d   = out_elem_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    priority if (in_fire) begin
      out_status_d = ctl.status;
      out_occ_d    = OccBits'(count_next);
      out_valid_d  = !ctl.rd_en;
      out_elem_d   = ctl.wr_en ? ValueBits'(wdata) : '0;
    end else if (state_q == ST_READ) begin
      out_elem_d  = ValueBits'(rdata);
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_elem_q   <= out_elem_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_occ_q, out_status_q, out_elem_q};

endmodule

### test/circular_deque_with_index_tb.sv
`timescale 1ns / 1ps

module circular_deque_with_index_tb;
  import cdq_pkg::*;

  localparam int unsigned RingDepth     = 256;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxWait       = 8;
  // kinds the block must answer with a plain ok and no change
  localparam logic [2:0]  KindSpareLo   = 3'd6;
  localparam logic [2:0]  KindSpareHi   = 3'd7;

  typedef struct packed {
    logic [31:0] element;
    status_e     status;
    logic [8:0]  occupancy;
  } deque_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // position[7:0], item_value[39:8]
  logic [2:0]  s_axis_tuser  = '0;  // kind[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // element_out[31:0], status[33:32], occupancy[42:34]

  // shadow copy of the deque
  logic [31:0] shadow_ring [RingDepth];
  logic [7:0]  shadow_head  = '0;
  logic [8:0]  shadow_count = '0;

  deque_result_t expected_words[$];

  bit steady_flow   = 1'b0;
  int rx_hold       = 0;
  int stall_cycles  = 0;
  int error_count   = 0;
  int requests_sent = 0;
  int words_checked = 0;
  int status_seen [4] = '{default: 0};

  circular_deque_with_index dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // applies one request to the shadow deque and returns the word it should give
  function automatic deque_result_t deque_apply(logic [2:0] kind, logic [7:0] pos,
                                                logic [31:0] value);
    deque_result_t r;
    logic [7:0]    slot;
    r = '{element: '0, status: STATUS_OK, occupancy: '0};
    case (kind)
      KIND_READ, KIND_OVERWRITE: begin
        if ({1'b0, pos} >= shadow_count) begin
          r.status = STATUS_RANGE;
        end else begin
          slot = shadow_head + pos;
          if (kind == KIND_OVERWRITE) shadow_ring[slot] = value;
          r.element = shadow_ring[slot];
        end
      end
      KIND_PUSH_BACK: begin
        if (shadow_count == 9'(RingDepth)) begin
          r.status = STATUS_FULL;
        end else begin
          slot = shadow_head + shadow_count[7:0];
          shadow_ring[slot] = value;
          shadow_count++;
          r.element = value;
        end
      end
      KIND_PUSH_FRONT: begin
        if (shadow_count == 9'(RingDepth)) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_head = shadow_head - 8'd1;
          shadow_ring[shadow_head] = value;
          shadow_count++;
          r.element = value;
        end
      end
      KIND_POP_BACK: begin
        if (shadow_count == '0) begin
          r.status = STATUS_EMPTY;
        end else begin
          slot = shadow_head + 8'(shadow_count - 9'd1);
          r.element = shadow_ring[slot];
          shadow_count--;
        end
      end
      KIND_POP_FRONT: begin
        if (shadow_count == '0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.element = shadow_ring[shadow_head];
          shadow_head = shadow_head + 8'd1;
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count;
    return r;
  endfunction

  // drives one request and waits for it to be taken; tvalid stays up afterwards
  task automatic send_request(input logic [2:0] kind, input logic [7:0] pos,
                              input logic [31:0] value);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, MaxWait);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {value, pos};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_words.push_back(deque_apply(kind, pos, value));
    requests_sent++;
  endtask

  task automatic send_random_request(input int push_pct, input int pop_pct);
    logic [2:0] kind;
    logic [7:0] pos;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      kind = $urandom_range(0, 1) ? KindSpareHi : KindSpareLo;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct)
        kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      else if (pick < push_pct + pop_pct)
        kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
      else
        kind = $urandom_range(0, 1) ? KIND_OVERWRITE : KIND_READ;
    end
    // mostly valid indexes, some anywhere in the field
    if (shadow_count != '0 && $urandom_range(0, 9) != 0)
      pos = 8'($urandom_range(0, int'(shadow_count) - 1));
    else
      pos = 8'($urandom());
    send_request(kind, pos, $urandom());
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_corner_requests();
    send_request(KIND_READ, 8'd0, 32'h0);
    send_request(KIND_OVERWRITE, 8'hFF, 32'hFFFF_FFFF);
    send_request(KIND_POP_BACK, 8'd0, 32'h0);
    send_request(KIND_POP_FRONT, 8'hFF, 32'hFFFF_FFFF);
    send_request(KindSpareLo, 8'hFF, 32'hFFFF_FFFF);
    send_request(KindSpareHi, 8'h00, 32'h0);
    send_request(KIND_PUSH_BACK, 8'd0, 32'h0000_0000);
    // head steps below slot zero and wraps to the top
    send_request(KIND_PUSH_FRONT, 8'd0, 32'hFFFF_FFFF);
    send_request(KIND_PUSH_BACK, 8'd0, 32'h8000_0001);
    send_request(KIND_READ, 8'd0, 32'h0);
    send_request(KIND_READ, 8'd2, 32'h0);
    send_request(KIND_READ, 8'd3, 32'h0);
    send_request(KIND_OVERWRITE, 8'd1, 32'h5A5A_A5A5);
    send_request(KIND_READ, 8'd1, 32'h0);
    send_request(KIND_READ, 8'hFF, 32'h0);
    send_request(KindSpareHi, 8'd1, 32'h1234_5678);
    send_request(KIND_POP_FRONT, 8'd0, 32'h0);
    send_request(KIND_POP_BACK, 8'd0, 32'h0);
    send_request(KIND_POP_BACK, 8'd0, 32'h0);
    send_request(KIND_POP_FRONT, 8'd0, 32'h0);
    send_request(KIND_PUSH_FRONT, 8'h80, 32'hC3C3_3C3C);
    send_request(KIND_POP_BACK, 8'h7F, 32'h0);
  endtask

  task automatic test_fill_to_capacity();
    steady_flow = 1'b1;
    while (shadow_count < 9'(RingDepth))
      send_request($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                   8'($urandom()), $urandom());
    steady_flow = 1'b0;
    send_request(KIND_PUSH_BACK, 8'($urandom()), $urandom());
    send_request(KIND_PUSH_FRONT, 8'($urandom()), $urandom());
    send_request(KIND_READ, 8'd0, 32'h0);
    send_request(KIND_READ, 8'hFF, 32'h0);
    send_request(KIND_OVERWRITE, 8'hFF, $urandom());
    send_request(KIND_READ, 8'hFF, 32'h0);
    // hover around full so full rejects and wrapped indexes keep coming
    repeat (120) send_random_request(55, 25);
    while (shadow_count != '0)
      send_request($urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT,
                   8'($urandom()), $urandom());
    send_request(KIND_POP_BACK, 8'd0, 32'h0);
    send_request(KIND_POP_FRONT, 8'd0, 32'h0);
  endtask

  task automatic test_sender_pause();
    repeat (40) send_random_request(45, 20);
    hold_until_drained();
    repeat (40) send_random_request(30, 40);
  endtask

  task automatic test_random_walk();
    int i;
    for (i = 0; i < 1100; i++) begin
      if (i % 150 == 0) steady_flow = ($urandom_range(0, 2) == 0);
      if (shadow_count < 9'd16)
        send_random_request(50, 20);
      else if (shadow_count > 9'd240)
        send_random_request(20, 50);
      else
        send_random_request(35, 35);
    end
    steady_flow = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    deque_result_t want;
    logic [31:0]   got_element;
    status_e       got_status;
    logic [8:0]    got_occupancy;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_element   = m_axis_tdata[31:0];
      got_status    = status_e'(m_axis_tdata[33:32]);
      got_occupancy = m_axis_tdata[42:34];
      if (expected_words.size() == 0) begin
        $error("word with nothing expected: element %h status %0d occupancy %0d",
               got_element, got_status, got_occupancy);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (got_element !== want.element) begin
          $error("element_out: expected %h, got %h", want.element, got_element);
          error_count++;
        end
        if (got_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got_status);
          error_count++;
        end
        if (got_occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, got_occupancy);
          error_count++;
        end
        status_seen[want.status]++;
      end
      words_checked++;
      rx_hold = steady_flow ? 0 : $urandom_range(0, MaxWait);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("circular_deque_with_index_tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_corner_requests();
    test_fill_to_capacity();
    test_sender_pause();
    test_random_walk();
    hold_until_drained();
    repeat (6) @(posedge clk_i);
    $display("%0d requests sent, %0d words checked", requests_sent, words_checked);
    $display("ok %0d, full %0d, empty %0d, out of range %0d; ring filled and emptied",
             status_seen[STATUS_OK], status_seen[STATUS_FULL],
             status_seen[STATUS_EMPTY], status_seen[STATUS_RANGE]);
    if (error_count == 0) begin
      $display("circular_deque_with_index_tb: clean");
    end else begin
      $display("circular_deque_with_index_tb: errors");
    end
    $finish;
  end

endmodule
